// ===== design/iphp_pkg.sv =====
// Package for the IPv4 header parser: payload structs, result codes and
// configuration indexes. No dependencies; every design file imports it.
package iphp_pkg;

    // Number of header bytes kept for decoding.
    localparam int C_MIN_HEADER_BYTES = 20;

    // Default number of packet records between the front and back parts.
    localparam int C_QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [0:0] C_CFG_MAX_JUMBO = 1'b0;
    localparam logic [0:0] C_CFG_QUICK     = 1'b1;

    localparam logic [15:0] C_MAX_JUMBO_RESET = 16'd9000;
    localparam logic [7:0]  C_IP_VERSION      = 8'h04;

    // Protocol numbers with their own payload kind.
    localparam logic [7:0] C_PROTO_ICMP = 8'd1;
    localparam logic [7:0] C_PROTO_TCP  = 8'd6;
    localparam logic [7:0] C_PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_SHORT_FRAME     = 3'd1,
        ST_BAD_VERSION     = 3'd2,
        ST_HEADER_SHORT    = 3'd3,
        ST_TOTAL_TOO_LARGE = 3'd4,
        ST_HEADER_LONG     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PK_NONE     = 3'd0,
        PK_TCP      = 3'd1,
        PK_ICMP     = 3'd2,
        PK_UDP      = 3'd3,
        PK_RAW      = 3'd4,
        PK_FRAGMENT = 3'd5
    } t_kind;

    // One byte of a packet.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    // One parse result.
    typedef struct packed {
        t_status     status;
        logic [5:0]  header_bytes;
        logic [15:0] total_length;
        logic [15:0] ident;
        logic        dont_fragment;
        logic        more_fragments;
        logic [15:0] frag_offset_bytes;
        logic [7:0]  ttl;
        logic [7:0]  protocol_number;
        t_kind       payload_kind;
        logic [31:0] source_address;
        logic [31:0] dest_address;
    } t_out_item;

    // Header bytes, hdr[k] is header byte k.
    typedef logic [C_MIN_HEADER_BYTES-1:0][7:0] t_hdr;

    // Finished packet handed from the front part to the back part.
    typedef struct packed {
        logic [15:0] len;
        t_hdr        hdr;
    } t_pkt_rec;

    // Fill status of the record queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== design/ipv4_header_parser_top.sv =====
// Top level of the IPv4 header parser: front capture, record queue and
// back decode. Depends on iphp_pkg, iphp_front, iphp_queue and iphp_back.
//
// Usage: packet bytes enter on the input channel (i_in_valid / o_in_ready),
// one transfer per byte in network order, first_byte and last_byte marking
// the packet boundaries. Each last byte yields exactly one result on the
// output channel (o_out_valid / i_out_ready); other bytes yield none.
// Throughput is one byte per clock cycle while the record queue is not full.
// The edge that transfers the last byte of a packet writes its record into
// the queue; a later edge moves the decoded result into the output register
// once that register is empty or being drained. Decode is combinational.
// When the receiver stalls, finished records collect in the queue of
// QUEUE_DEPTH entries behind the output register; o_in_ready drops only
// when that queue is full, and returns as soon as a result is taken.
// Reset (synchronous, active low) clears the byte count, the queue and the
// output valid, and sets max_jumbo_size to 9000 and quick_mode to 0.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
// the next edge and belong in idle periods.
module ipv4_header_parser_top import iphp_pkg::*; #(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic          push;
    logic          pop;
    t_pkt_rec      rec_in;
    t_pkt_rec      rec_head;
    t_queue_status queue_status;

    // Byte capture and length count.
    iphp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_item      (i_in_item),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_rec          (rec_in)
    );

    // Packet records waiting for decode.
    iphp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (rec_in),
        .i_pop    (pop),
        .o_rec    (rec_head),
        .o_status (queue_status)
    );

    // Header checks, decode and result register.
    iphp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rec          (rec_head),
        .i_queue_status (queue_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_item     (o_out_item)
    );

endmodule

// ===== design/iphp_front.sv =====
// Front part of the IPv4 header parser: accepts bytes, counts the packet
// length and captures the header. Depends on iphp_pkg.
module iphp_front import iphp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in_item      i_in_item,
    input  t_queue_status i_queue_status,
    output logic          o_push,
    output t_pkt_rec      o_rec
);

    logic [15:0] r_byte_count;
    logic [15:0] n_byte_count;
    t_hdr        r_hdr;
    t_hdr        n_hdr;
    logic        accept;
    logic [15:0] idx;
    logic [15:0] len;

    // A byte is taken whenever the queue can hold a finished packet.
    assign o_in_ready = !i_queue_status.full;
    assign accept     = i_in_valid && o_in_ready;

    // Byte position and observed length, saturating at the top.
    assign idx = i_in_item.first_byte ? 16'd0 : r_byte_count;
    assign len = (idx != 16'hFFFF) ? idx + 16'd1 : 16'hFFFF;

    // Header capture, including the byte of this transfer.
    always_comb begin
        n_hdr = r_hdr;
        for (int k = 0; k < C_MIN_HEADER_BYTES; k++) begin
            if (accept && idx == 16'(k)) begin
                n_hdr[k] = i_in_item.data_byte;
            end
        end
    end

    // Length counter restarts after the last byte of a packet.
    always_comb begin
        n_byte_count = r_byte_count;
        if (accept) begin
            n_byte_count = i_in_item.last_byte ? 16'd0 : len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
        end else begin
            r_byte_count <= n_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    // The last byte hands the whole packet record to the queue.
    assign o_push    = accept && i_in_item.last_byte;
    assign o_rec.len = len;
    assign o_rec.hdr = n_hdr;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_push && i_queue_status.full))
        else $error("record pushed into a full queue");

    a_count_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_byte_count == 16'd0)
        else $error("byte count not cleared after last byte");

endmodule

// ===== design/iphp_queue.sv =====
// Short queue of packet records between the front and back parts.
// Depends on iphp_pkg.
module iphp_queue import iphp_pkg::*; #(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_pkt_rec      i_rec,
    input  logic          i_pop,
    output t_pkt_rec      o_rec,
    output t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pkt_rec           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_rec          = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Record storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("record popped from an empty queue");

endmodule

// ===== design/iphp_back.sv =====
// Back part of the IPv4 header parser: checks a packet record, decodes the
// header fields and holds the result for the receiver. Depends on iphp_pkg.
module iphp_back import iphp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    input  t_pkt_rec      i_rec,
    input  t_queue_status i_queue_status,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out_item     o_out_item
);

    logic [15:0] r_max_jumbo;
    logic        r_quick;
    logic        r_out_valid;
    logic        n_out_valid;
    t_out_item   r_out;
    t_out_item   res;

    logic [7:0]  b0;
    logic [3:0]  ver;
    logic [5:0]  hl;
    logic [15:0] len;
    logic [15:0] total_field;
    logic [15:0] frag;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_jumbo <= C_MAX_JUMBO_RESET;
            r_quick     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                C_CFG_MAX_JUMBO: r_max_jumbo <= i_cfg_data;
                C_CFG_QUICK:     r_quick     <= i_cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign b0          = i_rec.hdr[0];
    assign ver         = b0[7:4];
    assign hl          = {b0[3:0], 2'b00};
    assign len         = i_rec.len;
    assign total_field = {i_rec.hdr[2], i_rec.hdr[3]};
    assign frag        = {i_rec.hdr[6][4:0], i_rec.hdr[7], 3'b000};

    // Header checks and field decode for the record at the queue head.
    always_comb begin
        logic [15:0] eff;
        eff = len;
        res = '0;
        if (len < 16'(C_MIN_HEADER_BYTES)) begin
            res.status = ST_SHORT_FRAME;
        end else if ({4'd0, ver} != C_IP_VERSION) begin
            res.status = ST_BAD_VERSION;
        end else if (hl < 6'(C_MIN_HEADER_BYTES)) begin
            res.status = ST_HEADER_SHORT;
        end else if (total_field > r_max_jumbo && total_field > len) begin
            res.status = ST_TOTAL_TOO_LARGE;
        end else begin
            res.status = (!r_quick && 16'(hl) > len) ? ST_HEADER_LONG : ST_OK;
            res.total_length = total_field;
            if (total_field == 16'd0) begin
                res.total_length = len;
            end else if (total_field < len) begin
                eff = total_field;
            end
            res.header_bytes      = hl;
            res.ident             = {i_rec.hdr[4], i_rec.hdr[5]};
            res.dont_fragment     = i_rec.hdr[6][6];
            res.more_fragments    = i_rec.hdr[6][5];
            res.frag_offset_bytes = frag;
            res.ttl               = i_rec.hdr[8];
            res.protocol_number   = i_rec.hdr[9];
            res.source_address    = {i_rec.hdr[12], i_rec.hdr[13],
                                     i_rec.hdr[14], i_rec.hdr[15]};
            res.dest_address      = {i_rec.hdr[16], i_rec.hdr[17],
                                     i_rec.hdr[18], i_rec.hdr[19]};
            if (frag != 16'd0 || i_rec.hdr[6][5]) begin
                res.payload_kind = PK_FRAGMENT;
            end else if (16'(hl) + 16'd1 < eff) begin
                unique case (i_rec.hdr[9])
                    C_PROTO_TCP:  res.payload_kind = PK_TCP;
                    C_PROTO_ICMP: res.payload_kind = PK_ICMP;
                    C_PROTO_UDP:  res.payload_kind = PK_UDP;
                    default:      res.payload_kind = PK_RAW;
                endcase
            end else begin
                res.payload_kind = PK_NONE;
            end
        end
    end

    // The output register takes a new result when empty or being drained.
    assign o_pop = !i_queue_status.empty && (!r_out_valid || i_out_ready);

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_pop_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped record did not reach the output register");

    a_reject_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_OK && r_out.status != ST_HEADER_LONG
        |-> r_out.header_bytes == 6'd0 && r_out.total_length == 16'd0)
        else $error("rejected packet carries decoded fields");

endmodule
